### rtl/leb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line edit buffer package
// Shared constants, codes, state and command types of the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

   localparam int LINE_CAP_DEFAULT = 64;
   localparam int KEY_W            = 8;
   localparam int LEN_W            = 7;
   localparam int KIND_W           = 2;
   localparam int NUM_REGS         = 7;
   localparam int REG_IDX_W        = 3;

   // Configuration register indexes.
   localparam logic [REG_IDX_W-1:0] REG_RETURN    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_UP        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DOWN      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RIGHT     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LEFT      = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ALT_ERASE = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_ERASE     = 3'd6;

   localparam logic [KEY_W-1:0] REG_RESET [NUM_REGS] = '{
      8'd13, 8'd128, 8'd129, 8'd130, 8'd131, 8'd127, 8'd8
   };

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

   typedef enum logic [2:0] {
      KEY_RETURN,
      KEY_IGNORE,
      KEY_RIGHT,
      KEY_LEFT,
      KEY_ERASE,
      KEY_INSERT
   } key_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_R,
      ST_DRAIN_R,
      ST_PUT,
      ST_SHIFT_L,
      ST_DRAIN_L,
      ST_EMIT,
      ST_EMIT_END
   } state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_CUR,
      PTR_LENM1,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef enum logic [1:0] {
      RSP_NONE,
      RSP_STATUS,
      RSP_EMPTY
   } rsp_op_type;

   typedef struct packed {
      logic       accept;
      ptr_op_type ptr_op;
      logic       shift_r;
      logic       shift_l;
      logic       emit_rd;
      logic       emit_last;
      logic       put_key;
      logic       len_inc;
      logic       len_dec;
      logic       cur_inc;
      logic       cur_dec;
      logic       clear;
      rsp_op_type rsp_op;
      logic       redraw;
      logic       refused;
   } cmd_type;

   typedef struct packed {
      key_class_type cls;
      logic          len_zero;
      logic          cur_zero;
      logic          cur_lt_len;
      logic          full;
      logic          ptr_at_cur;
      logic          ptr_at_lenm1;
   } status_type;

endpackage
`default_nettype wire

### rtl/leb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module leb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

### rtl/leb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line edit buffer controller
// Sequences key decode, tail shifts, key insertion and line emission.
// ----------------------------------------------------------------------------
module leb_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire leb_pkg::status_type status,
   output leb_pkg::cmd_type         cmd
);

   leb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= leb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != leb_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         leb_pkg::ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               unique case (status.cls)
                  leb_pkg::KEY_RETURN: begin
                     if (status.len_zero) begin
                        cmd.clear  = 1'b1;
                        cmd.rsp_op = leb_pkg::RSP_EMPTY;
                     end else begin
                        cmd.ptr_op = leb_pkg::PTR_ZERO;
                        state_in   = leb_pkg::ST_EMIT;
                     end
                  end
                  leb_pkg::KEY_IGNORE: begin
                     cmd.rsp_op = leb_pkg::RSP_STATUS;
                  end
                  leb_pkg::KEY_RIGHT: begin
                     cmd.rsp_op  = leb_pkg::RSP_STATUS;
                     cmd.cur_inc = status.cur_lt_len;
                     cmd.redraw  = status.cur_lt_len;
                  end
                  leb_pkg::KEY_LEFT: begin
                     cmd.rsp_op  = leb_pkg::RSP_STATUS;
                     cmd.cur_dec = !status.cur_zero;
                     cmd.redraw  = !status.cur_zero;
                  end
                  leb_pkg::KEY_ERASE: begin
                     if (status.len_zero || status.cur_zero) begin
                        cmd.rsp_op = leb_pkg::RSP_STATUS;
                     end else if (status.cur_lt_len) begin
                        cmd.ptr_op = leb_pkg::PTR_CUR;
                        state_in   = leb_pkg::ST_SHIFT_L;
                     end else begin
                        // Cursor at the end: nothing to move, just drop the last character.
                        cmd.len_dec = 1'b1;
                        cmd.cur_dec = 1'b1;
                        cmd.redraw  = 1'b1;
                        cmd.rsp_op  = leb_pkg::RSP_STATUS;
                     end
                  end
                  leb_pkg::KEY_INSERT: begin
                     if (status.full) begin
                        cmd.refused = 1'b1;
                        cmd.rsp_op  = leb_pkg::RSP_STATUS;
                     end else if (status.cur_lt_len) begin
                        cmd.ptr_op = leb_pkg::PTR_LENM1;
                        state_in   = leb_pkg::ST_SHIFT_R;
                     end else begin
                        state_in = leb_pkg::ST_PUT;
                     end
                  end
                  default: begin
                     cmd.rsp_op = leb_pkg::RSP_STATUS;
                  end
               endcase
            end
         end
         leb_pkg::ST_SHIFT_R: begin
            cmd.shift_r = 1'b1;
            cmd.ptr_op  = leb_pkg::PTR_DEC;
            if (status.ptr_at_cur) begin
               state_in = leb_pkg::ST_DRAIN_R;
            end
         end
         leb_pkg::ST_DRAIN_R: begin
            state_in = leb_pkg::ST_PUT;
         end
         leb_pkg::ST_PUT: begin
            cmd.put_key = 1'b1;
            cmd.len_inc = 1'b1;
            cmd.cur_inc = 1'b1;
            cmd.redraw  = 1'b1;
            cmd.rsp_op  = leb_pkg::RSP_STATUS;
            state_in    = leb_pkg::ST_IDLE;
         end
         leb_pkg::ST_SHIFT_L: begin
            cmd.shift_l = 1'b1;
            cmd.ptr_op  = leb_pkg::PTR_INC;
            if (status.ptr_at_lenm1) begin
               state_in = leb_pkg::ST_DRAIN_L;
            end
         end
         leb_pkg::ST_DRAIN_L: begin
            cmd.len_dec = 1'b1;
            cmd.cur_dec = 1'b1;
            cmd.redraw  = 1'b1;
            cmd.rsp_op  = leb_pkg::RSP_STATUS;
            state_in    = leb_pkg::ST_IDLE;
         end
         leb_pkg::ST_EMIT: begin
            cmd.emit_rd = 1'b1;
            cmd.ptr_op  = leb_pkg::PTR_INC;
            if (status.ptr_at_lenm1) begin
               state_in = leb_pkg::ST_EMIT_END;
            end
         end
         leb_pkg::ST_EMIT_END: begin
            // The final character read is still in flight and goes out marked last.
            cmd.emit_last = 1'b1;
            cmd.clear     = 1'b1;
            state_in      = leb_pkg::ST_IDLE;
         end
         default: begin
            state_in = leb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/leb_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line edit buffer datapath
// Code registers, key decode, length and cursor, line store and result word.
// ----------------------------------------------------------------------------
module leb_dp #(
   parameter int LINE_CAP = leb_pkg::LINE_CAP_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [leb_pkg::KEY_W-1:0]     req_key,
   input  wire logic                          csr_we,
   input  wire logic [leb_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [leb_pkg::KEY_W-1:0]     csr_wdata,
   input  wire leb_pkg::cmd_type              cmd,
   output leb_pkg::status_type                status,
   output logic                               rsp_valid,
   output logic [leb_pkg::KIND_W-1:0]         rsp_kind,
   output logic [leb_pkg::KEY_W-1:0]          rsp_line_char,
   output logic                               rsp_last,
   output logic [leb_pkg::LEN_W-1:0]          rsp_line_length,
   output logic [leb_pkg::LEN_W-1:0]          rsp_cursor_position,
   output logic                               rsp_redraw,
   output logic                               rsp_refused
);

   localparam int AW    = $clog2(LINE_CAP);
   localparam int LEN_W = leb_pkg::LEN_W;
   localparam int KEY_W = leb_pkg::KEY_W;

   logic [KEY_W-1:0] cfg_ff [leb_pkg::NUM_REGS];
   logic [KEY_W-1:0] key_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cur_ff, cur_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic             pend_wr_ff, pend_wr_in;
   logic [AW-1:0]    wa_ff, wa_in;
   logic             pend_emit_ff, pend_emit_in;
   logic [LEN_W-1:0] len_m1;

   leb_pkg::key_class_type key_cls;

   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [KEY_W-1:0] ram_wr_data;
   logic [KEY_W-1:0] ram_rd_data;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [leb_pkg::KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]                 rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]                 rsp_len_ff, rsp_len_in;
   logic [LEN_W-1:0]                 rsp_cur_ff, rsp_cur_in;
   logic                             rsp_redraw_ff, rsp_redraw_in;
   logic                             rsp_refused_ff, rsp_refused_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= leb_pkg::REG_RESET;
      end else if (csr_we && (csr_index < leb_pkg::REG_IDX_W'(leb_pkg::NUM_REGS))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // Codes are matched in a fixed order; the first match wins.
   always_comb begin
      priority if (req_key == cfg_ff[leb_pkg::REG_RETURN]) begin
         key_cls = leb_pkg::KEY_RETURN;
      end else if ((req_key == cfg_ff[leb_pkg::REG_UP]) ||
                   (req_key == cfg_ff[leb_pkg::REG_DOWN])) begin
         key_cls = leb_pkg::KEY_IGNORE;
      end else if (req_key == cfg_ff[leb_pkg::REG_RIGHT]) begin
         key_cls = leb_pkg::KEY_RIGHT;
      end else if (req_key == cfg_ff[leb_pkg::REG_LEFT]) begin
         key_cls = leb_pkg::KEY_LEFT;
      end else if ((req_key == cfg_ff[leb_pkg::REG_ALT_ERASE]) ||
                   (req_key == cfg_ff[leb_pkg::REG_ERASE])) begin
         key_cls = leb_pkg::KEY_ERASE;
      end else begin
         key_cls = leb_pkg::KEY_INSERT;
      end
   end

   assign status.cls          = key_cls;
   assign len_m1              = len_ff - LEN_W'(1);
   assign status.len_zero     = (len_ff == '0);
   assign status.cur_zero     = (cur_ff == '0);
   assign status.cur_lt_len   = (cur_ff < len_ff);
   assign status.full         = (len_ff >= LEN_W'(LINE_CAP));
   assign status.ptr_at_cur   = (LEN_W'(ptr_ff) == cur_ff);
   assign status.ptr_at_lenm1 = (LEN_W'(ptr_ff) == len_m1);

   always_comb begin
      unique case (cmd.ptr_op)
         leb_pkg::PTR_HOLD:  ptr_in = ptr_ff;
         leb_pkg::PTR_ZERO:  ptr_in = '0;
         leb_pkg::PTR_CUR:   ptr_in = cur_ff[AW-1:0];
         leb_pkg::PTR_LENM1: ptr_in = len_m1[AW-1:0];
         leb_pkg::PTR_INC:   ptr_in = ptr_ff + AW'(1);
         leb_pkg::PTR_DEC:   ptr_in = ptr_ff - AW'(1);
         default:            ptr_in = ptr_ff;
      endcase

      priority if (cmd.clear) begin
         len_in = '0;
      end else if (cmd.len_inc) begin
         len_in = len_ff + LEN_W'(1);
      end else if (cmd.len_dec) begin
         len_in = len_m1;
      end else begin
         len_in = len_ff;
      end

      priority if (cmd.clear) begin
         cur_in = '0;
      end else if (cmd.cur_inc) begin
         cur_in = cur_ff + LEN_W'(1);
      end else if (cmd.cur_dec) begin
         cur_in = cur_ff - LEN_W'(1);
      end else begin
         cur_in = cur_ff;
      end

      // A character read this cycle lands one place over next cycle: up for a right shift, down for a left shift.
      pend_wr_in   = cmd.shift_r | cmd.shift_l;
      wa_in        = cmd.shift_r ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
      pend_emit_in = cmd.emit_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         cur_ff       <= '0;
         pend_wr_ff   <= 1'b0;
         pend_emit_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         pend_wr_ff   <= pend_wr_in;
         pend_emit_ff <= pend_emit_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      wa_ff  <= wa_in;
      if (cmd.accept) begin
         key_ff <= req_key;
      end
   end

   assign ram_wr_en   = pend_wr_ff | cmd.put_key;
   assign ram_wr_addr = cmd.put_key ? cur_ff[AW-1:0] : wa_ff;
   assign ram_wr_data = cmd.put_key ? key_ff : ram_rd_data;

   leb_ram #(
      .WIDTH (KEY_W),
      .DEPTH (LINE_CAP)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Result word.
   always_comb begin
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = leb_pkg::KIND_STATUS;
      rsp_char_in    = '0;
      rsp_last_in    = 1'b1;
      rsp_len_in     = len_in;
      rsp_cur_in     = cur_in;
      rsp_redraw_in  = cmd.redraw;
      rsp_refused_in = cmd.refused;
      if (pend_emit_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = leb_pkg::KIND_CHAR;
         rsp_char_in    = ram_rd_data;
         rsp_last_in    = cmd.emit_last;
         rsp_len_in     = '0;
         rsp_cur_in     = '0;
         rsp_redraw_in  = 1'b1;
         rsp_refused_in = 1'b0;
      end else begin
         unique case (cmd.rsp_op)
            leb_pkg::RSP_STATUS: begin
               rsp_valid_in = 1'b1;
            end
            leb_pkg::RSP_EMPTY: begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = leb_pkg::KIND_EMPTY;
               rsp_len_in     = '0;
               rsp_cur_in     = '0;
               rsp_redraw_in  = 1'b0;
               rsp_refused_in = 1'b0;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_len_ff     <= rsp_len_in;
      rsp_cur_ff     <= rsp_cur_in;
      rsp_redraw_ff  <= rsp_redraw_in;
      rsp_refused_ff <= rsp_refused_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_line_char       = rsp_char_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_line_length     = rsp_len_ff;
   assign rsp_cursor_position = rsp_cur_ff;
   assign rsp_redraw          = rsp_redraw_ff;
   assign rsp_refused         = rsp_refused_ff;

endmodule
`default_nettype wire

### rtl/line_edit_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Cursor moves, ignored keys, refusals, erases at the line end or with nothing to erase and
// return on an empty line give their word in the cycle after start. Insert inside the line
// passes the right-shift, drain and put states, at the line end only put; erase inside the
// line the left-shift and drain states, one character moved per cycle through the store's
// single write port; busy drops as the word goes out. Return sends one character word per
// cycle, the last marked. Synchronous reset empties the line and restores the key codes.
// ----------------------------------------------------------------------------
// Line edit buffer
// Edits a line of key bytes with a cursor and sends the finished line on return.
// ----------------------------------------------------------------------------
module line_edit_buffer_top #(
   parameter int LINE_CAP = leb_pkg::LINE_CAP_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [leb_pkg::KEY_W-1:0]     req_key,
   output logic                               rsp_valid,
   output logic [leb_pkg::KIND_W-1:0]         rsp_kind,
   output logic [leb_pkg::KEY_W-1:0]          rsp_line_char,
   output logic                               rsp_last,
   output logic [leb_pkg::LEN_W-1:0]          rsp_line_length,
   output logic [leb_pkg::LEN_W-1:0]          rsp_cursor_position,
   output logic                               rsp_redraw,
   output logic                               rsp_refused,
   input  wire logic                          csr_we,
   input  wire logic [leb_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [leb_pkg::KEY_W-1:0]     csr_wdata
);

   leb_pkg::cmd_type    cmd;
   leb_pkg::status_type status;

   leb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   leb_dp #(
      .LINE_CAP (LINE_CAP)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_key             (req_key),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_line_char       (rsp_line_char),
      .rsp_last            (rsp_last),
      .rsp_line_length     (rsp_line_length),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_redraw          (rsp_redraw),
      .rsp_refused         (rsp_refused)
   );

endmodule
`default_nettype wire
